>>> src/smta_pkg.sv
// shared widths, sequencer codes and histogram command type for the median alarm unit
package smta_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LEN_W    = 13;
    localparam int TM_W     = 9;
    localparam int TOTAL_W  = 32;

    typedef struct packed {
        logic wr;
        logic clr;
    } t_hist_cmd;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WALK   = 7'b0000010,
        S_CMP    = 7'b0000100,
        S_DEC    = 7'b0001000,
        S_INC_RD = 7'b0010000,
        S_INC    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

endpackage

>>> src/smta_hist.sv
// histogram bin store: one write port, one registered read port, per-bin valid flags
module smta_hist #(
    parameter int NUM_BINS = 201,
    parameter int AW       = 8,
    parameter int DW       = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smta_pkg::t_hist_cmd  i_cmd,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [DW-1:0]        i_wr_data,
    output logic [DW-1:0]        o_rd_data
);
    import smta_pkg::*;

    logic [DW-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_vld;
    logic [DW-1:0] r_q;
    logic          r_qv;

    // valid flags stand in for clearing the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q  <= r_mem[i_rd_addr];
        r_qv <= r_vld[i_rd_addr];
    end

    assign o_rd_data = r_qv ? r_q : '0;

endmodule

>>> src/sliding_median_threshold_alarm_unit.sv
// top level: sliding window median threshold alarm with a bin-walking sequencer
//
//  channel   direction  handshake            payload
//  in        in         i_valid / o_ready    i_sample
//  out       out        o_valid / i_ready    o_alarm, o_window_full, o_twice_median,
//                                            o_alarm_total
//  cfg       in         i_cfg_we             i_cfg_data (window length)
//
// a word that only fills the window passes through S_INC_RD, S_INC and S_FIN to the output register
// on a full window the walk reads one bin a cycle through the bin store's registered port,
// then S_CMP, S_DEC, S_INC_RD, S_INC and S_FIN follow; o_ready is high only while the sequencer is idle
// a finished result waits in the output register, so the next word may be taken meanwhile
// reset is synchronous and active low; bins are cleared at once through per-bin valid flags
// a window length write empties the window (bins, ring pointer, fill count), the total is kept
module sliding_median_threshold_alarm_unit #(
    parameter int MAX_WINDOW = 4096,
    parameter int MAX_VALUE  = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [smta_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_alarm,
    output logic                          o_window_full,
    output logic [smta_pkg::TM_W-1:0]     o_twice_median,
    output logic [smta_pkg::TOTAL_W-1:0]  o_alarm_total,
    input  logic                          i_cfg_we,
    input  logic [smta_pkg::LEN_W-1:0]    i_cfg_data
);
    import smta_pkg::*;

    localparam int NUM_BINS = MAX_VALUE + 1;
    localparam int VW = $clog2(NUM_BINS);                          // bin index width
    localparam int CW = $clog2(MAX_WINDOW + 1);                    // counts and lengths
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1; // ring index
    localparam int XW = (VW > SAMPLE_W) ? VW : SAMPLE_W;           // sample compare width
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;                 // length compare width
    localparam logic [VW-1:0] MAXV = VW'(MAX_VALUE);

    t_state r_state;

    // window bookkeeping
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_fill;
    logic [PW-1:0] r_ptr;
    logic [TOTAL_W-1:0] r_acount;

    // per-word working registers
    logic [VW-1:0] r_smp;
    logic          r_full;
    logic [VW-1:0] r_ring_q;
    logic [VW-1:0] r_idx;
    logic [VW-1:0] r_pidx;
    logic          r_pend;
    logic [CW-1:0] r_cum;
    logic          r_have_lo;
    logic [VW-1:0] r_vlo;
    logic [VW-1:0] r_vhi;
    logic [VW:0]   r_tm;
    logic          r_alarm;

    // output register
    logic               r_ovld;
    logic               r_o_alarm;
    logic               r_o_full;
    logic [TM_W-1:0]    r_o_tm;
    logic [TOTAL_W-1:0] r_o_total;

    // ring of the samples in the window
    logic [VW-1:0] r_ring [MAX_WINDOW];

    logic          acc;
    logic [XW-1:0] smp_x;
    logic [VW-1:0] smp_sat;
    logic [CW-1:0] rank_lo;
    logic [CW-1:0] rank_hi;
    logic [CW-1:0] cum_n;
    logic [VW:0]   tm_sum;
    logic          alarm_n;
    logic [CW-1:0] ptr_inc;
    logic [LW-1:0] cfg_x;
    logic [CW-1:0] len_eff;
    logic          out_free;

    t_hist_cmd     hcmd;
    logic [VW-1:0] h_rd_addr;
    logic [VW-1:0] h_wr_addr;
    logic [CW-1:0] h_wr_data;
    logic [CW-1:0] h_rd_data;

    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    // saturate the incoming sample to the top bin
    assign smp_x   = XW'(i_sample);
    assign smp_sat = (smp_x > XW'(MAX_VALUE)) ? MAXV : VW'(smp_x);

    // middle ranks: equal for an odd window, adjacent for an even one
    assign rank_lo = (r_len - CW'(1)) >> 1;
    assign rank_hi = r_len >> 1;

    assign cum_n   = r_cum + h_rd_data;
    assign tm_sum  = {1'b0, r_vlo} + {1'b0, r_vhi};
    assign alarm_n = ({1'b0, r_smp} >= tm_sum);
    assign ptr_inc = CW'(r_ptr) + CW'(1);

    // window length of zero acts as one, above the ring depth acts as the depth
    assign cfg_x = LW'(i_cfg_data);
    always_comb begin
        if (cfg_x == '0) begin
            len_eff = CW'(1);
        end else if (cfg_x > LW'(MAX_WINDOW)) begin
            len_eff = CW'(MAX_WINDOW);
        end else begin
            len_eff = CW'(cfg_x);
        end
    end

    assign out_free = !r_ovld || i_ready;

    // bin store port steering by sequencer step
    always_comb begin
        hcmd.clr  = i_cfg_we;
        hcmd.wr   = 1'b0;
        h_rd_addr = r_smp;
        h_wr_addr = r_smp;
        h_wr_data = h_rd_data + CW'(1);
        case (r_state)
            S_WALK: begin
                h_rd_addr = r_idx;
            end
            S_CMP: begin
                h_rd_addr = r_ring_q;
            end
            S_DEC: begin
                hcmd.wr   = 1'b1;
                h_wr_addr = r_ring_q;
                h_wr_data = (h_rd_data != '0) ? h_rd_data - CW'(1) : '0;
            end
            S_INC: begin
                hcmd.wr = 1'b1;
            end
            default: begin
                h_rd_addr = r_smp;
            end
        endcase
    end

    smta_hist #(
        .NUM_BINS (NUM_BINS),
        .AW       (VW),
        .DW       (CW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (hcmd),
        .i_rd_addr (h_rd_addr),
        .i_wr_addr (h_wr_addr),
        .i_wr_data (h_wr_data),
        .o_rd_data (h_rd_data)
    );

    // ring: oldest sample read on acceptance, new sample written alongside the bin increment
    always_ff @(posedge i_clk) begin
        if (r_state == S_INC) begin
            r_ring[r_ptr] <= r_smp;
        end
        if (acc) begin
            r_ring_q <= r_ring[r_ptr];
        end
    end

    // sequencer and window control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= CW'(1);
            r_fill    <= '0;
            r_ptr     <= '0;
            r_acount  <= '0;
            r_ovld    <= 1'b0;
            r_pend    <= 1'b0;
            r_have_lo <= 1'b0;
            r_cum     <= '0;
        end else begin
            // a new result may replace one leaving in the same cycle
            if (r_state == S_FIN && out_free) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_len  <= len_eff;
                r_fill <= '0;
                r_ptr  <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_smp     <= smp_sat;
                        r_full    <= (r_fill >= r_len);
                        r_alarm   <= 1'b0;
                        r_tm      <= '0;
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_cum     <= '0;
                        r_have_lo <= 1'b0;
                        r_vlo     <= MAXV;
                        r_vhi     <= MAXV;
                        r_state   <= (r_fill >= r_len) ? S_WALK : S_INC_RD;
                    end
                end
                S_WALK: begin
                    // issue the next bin while the previous one is summed
                    r_idx  <= (r_idx == MAXV) ? r_idx : r_idx + VW'(1);
                    r_pidx <= r_idx;
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        r_cum <= cum_n;
                        if (!r_have_lo && (cum_n > rank_lo)) begin
                            r_vlo     <= r_pidx;
                            r_have_lo <= 1'b1;
                        end
                        if (cum_n > rank_hi) begin
                            r_vhi   <= r_pidx;
                            r_state <= S_CMP;
                        end else if (r_pidx == MAXV) begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    r_tm    <= tm_sum;
                    r_alarm <= alarm_n;
                    if (alarm_n) begin
                        r_acount <= r_acount + TOTAL_W'(1);
                    end
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_INC_RD;
                end
                S_INC_RD: begin
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_ptr <= (ptr_inc >= r_len) ? '0 : PW'(ptr_inc);
                    if (!r_full) begin
                        r_fill <= r_fill + CW'(1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_alarm <= r_alarm;
            r_o_full  <= r_full;
            r_o_tm    <= TM_W'(r_tm);
            r_o_total <= r_acount;
        end
    end

    assign o_valid        = r_ovld;
    assign o_alarm        = r_o_alarm;
    assign o_window_full  = r_o_full;
    assign o_twice_median = r_o_tm;
    assign o_alarm_total  = r_o_total;

`ifndef SYNTHESIS
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count beyond window length");

    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_ptr) < r_len)
        else $error("ring pointer beyond window length");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_pend && r_pidx == MAXV) |=> (r_state == S_CMP))
        else $error("bin walk ran past the top bin");

    a_cum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cum <= r_len))
        else $error("running bin sum beyond window length");

    a_alarm_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_alarm) |-> o_window_full)
        else $error("alarm raised while the window was filling");
`endif

endmodule
